// File: rtl/core/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define RRTS_ASSERT(lbl, clk, rstn, prop)
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned STRIDE_W = 21;
  localparam logic [31:0] DEF_BASE = 32'h000A_0000;
  localparam logic [STRIDE_W-1:0] DEF_STRIDE = 21'd8192;
  localparam logic [31:0] FRAME_FLAGS = 32'd512;
  localparam logic [31:0] FRAME_TOP_GAP = 32'd16;
  localparam int unsigned FRAME_REGS = 14;
  localparam int unsigned FRAME_WORDS = FRAME_REGS + 3;
  localparam logic [4:0] FRAME_LAST = 5'(FRAME_WORDS - 1);
  localparam logic [31:0] FRAME_BYTES = 32'(4 * FRAME_WORDS);

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_STRIDE = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE, ST_READY, ST_RUNNING, ST_SLEEPING
  } slot_state_e;

  typedef enum logic [1:0] {
    ACT_SCHEDULE, ACT_START, ACT_SLEEP, ACT_EXIT
  } action_e;

  typedef enum logic [1:0] {
    RES_OK, RES_NO_SLOT, RES_EXIT_REFUSED, RES_UNUSED
  } res_code_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CUR, S_SCAN, S_CHK, S_FIND, S_MUL, S_TOP, S_INIT, S_FRAME, S_EXIT, S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] now;
    logic [31:0] saved_sp;
    logic [31:0] blit_dest;
    logic [31:0] blit_width;
    logic [31:0] blit_height;
    logic [31:0] blit_source;
    logic [31:0] entry_address;
    logic [31:0] sleep_ticks;
  } item_t;

  typedef struct packed {
    logic [31:0] sp;
    logic [31:0] dest;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] source;
    logic [31:0] wake;
    logic [31:0] tick;
  } ctx_row_t;

  typedef struct packed {
    res_code_e   status;
    logic [2:0]  slot;
    logic [31:0] next_sp;
    logic [31:0] restore_dest;
    logic [31:0] restore_width;
    logic [31:0] restore_height;
    logic [31:0] restore_source;
    logic [3:0]  live_count;
    logic [31:0] switch_total;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/rrts_ctx_mem.sv
`default_nettype none
module rrts_ctx_mem #(
  parameter int unsigned Depth = rrts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output rrts_pkg::ctx_row_t            rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  rrts_pkg::ctx_row_t            wr_data_i
);

  rrts_pkg::ctx_row_t mem_q [Depth];
  rrts_pkg::ctx_row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// File: rtl/core/rrts_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module rrts_ctrl #(
  parameter int unsigned SlotCount = rrts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  rrts_pkg::item_t                       item_i,
  input  wire logic [31:0]                      base_i,
  input  wire logic [rrts_pkg::STRIDE_W-1:0]    stride_i,
  input  wire logic                             out_free_i,
  output logic                                  res_load_o,
  output rrts_pkg::result_t                     res_o
);

  localparam int unsigned IW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CW = $clog2(SlotCount + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SlotCount - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SlotCount);

  rrts_pkg::ctrl_state_e state_q, state_d;
  rrts_pkg::item_t       item_q, item_d;
  rrts_pkg::ctx_row_t    row_q, row_d;
  rrts_pkg::res_code_e   code_q, code_d;
  rrts_pkg::slot_state_e status_q [SlotCount];
  rrts_pkg::slot_state_e st_val, st_old;
  logic [SlotCount-1:0]  tv_q, tv_d;
  logic [IW-1:0]         cur_q, cur_d, k_q, k_d, k_next, st_idx;
  logic [CW-1:0]         cnt_q, cnt_d, live_q, live_d;
  logic [31:0]           sw_q, sw_d, top_q, top_d, addr_q, addr_d, prod_q, prod_d;
  logic [4:0]            j_q, j_d;
  logic                  st_we, hit, due;

  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  rrts_pkg::ctx_row_t    rd_data, wr_data;

  rrts_ctx_mem #(.Depth(SlotCount)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign k_next = (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
  assign due = ($signed(item_q.now) >= $signed(rd_data.wake));
  assign hit = ((status_q[k_q] == rrts_pkg::ST_SLEEPING) && due)
            || (status_q[k_q] == rrts_pkg::ST_READY)
            || (status_q[k_q] == rrts_pkg::ST_RUNNING);
  assign in_ready_o = (state_q == rrts_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (item_i.action)
            rrts_pkg::ACT_START: state_d = rrts_pkg::S_FIND;
            rrts_pkg::ACT_EXIT:  state_d = rrts_pkg::S_EXIT;
            default:             state_d = rrts_pkg::S_CUR;
          endcase
        end
      end
      rrts_pkg::S_CUR: begin
        state_d = (item_q.action == rrts_pkg::ACT_SCHEDULE) ? rrts_pkg::S_SCAN
                                                             : rrts_pkg::S_EMIT;
      end
      rrts_pkg::S_SCAN: state_d = rrts_pkg::S_CHK;
      rrts_pkg::S_CHK: begin
        state_d = (hit || cnt_q == FULL_CNT) ? rrts_pkg::S_EMIT : rrts_pkg::S_SCAN;
      end
      rrts_pkg::S_FIND: begin
        if (status_q[k_q] == rrts_pkg::ST_FREE) begin
          state_d = rrts_pkg::S_MUL;
        end else if (k_q == LAST_IDX) begin
          state_d = rrts_pkg::S_EMIT;
        end
      end
      rrts_pkg::S_MUL:  state_d = rrts_pkg::S_TOP;
      rrts_pkg::S_TOP:  state_d = rrts_pkg::S_INIT;
      rrts_pkg::S_INIT: state_d = rrts_pkg::S_FRAME;
      rrts_pkg::S_FRAME: begin
        if (out_free_i && j_q == rrts_pkg::FRAME_LAST) begin
          state_d = rrts_pkg::S_IDLE;
        end
      end
      rrts_pkg::S_EXIT: state_d = rrts_pkg::S_EMIT;
      rrts_pkg::S_EMIT: begin
        if (out_free_i) begin
          state_d = rrts_pkg::S_IDLE;
        end
      end
      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_d = item_q;
    row_d = row_q;
    code_d = code_q;
    tv_d = tv_q;
    cur_d = cur_q;
    k_d = k_q;
    cnt_d = cnt_q;
    sw_d = sw_q;
    top_d = top_q;
    addr_d = addr_q;
    prod_d = prod_q;
    j_d = j_q;
    st_we = 1'b0;
    st_idx = cur_q;
    st_val = rrts_pkg::ST_FREE;
    rd_en = 1'b0;
    rd_addr = cur_q;
    wr_en = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_data;
    res_load_o = 1'b0;
    res_o = '0;
    res_o.status = code_q;
    res_o.slot = 3'(cur_q);
    res_o.live_count = 4'(live_q);
    res_o.switch_total = sw_q;
    res_o.last = 1'b1;
    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d = item_i;
          rd_en = 1'b1;
          k_d = IW'(1);
          code_d = rrts_pkg::RES_OK;
        end
      end
      rrts_pkg::S_CUR: begin
        wr_en = 1'b1;
        if (item_q.action == rrts_pkg::ACT_SCHEDULE) begin
          wr_data.sp = item_q.saved_sp;
          wr_data.dest = item_q.blit_dest;
          wr_data.width = item_q.blit_width;
          wr_data.height = item_q.blit_height;
          wr_data.source = item_q.blit_source;
          wr_data.tick = (tv_q[cur_q] ? rd_data.tick : 32'd0) + 32'd1;
          tv_d[cur_q] = 1'b1;
          if (status_q[cur_q] == rrts_pkg::ST_RUNNING) begin
            st_we = 1'b1;
            st_val = rrts_pkg::ST_READY;
          end
          k_d = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
          cnt_d = CW'(1);
        end else begin
          wr_data.wake = item_q.now + item_q.sleep_ticks;
          st_we = 1'b1;
          st_val = rrts_pkg::ST_SLEEPING;
        end
      end
      rrts_pkg::S_SCAN: begin
        rd_en = 1'b1;
        rd_addr = k_q;
      end
      rrts_pkg::S_CHK: begin
        // last probe lands on the current slot, which is kept either way
        if (hit || cnt_q == FULL_CNT) begin
          row_d = rd_data;
          st_we = 1'b1;
          st_idx = k_q;
          st_val = rrts_pkg::ST_RUNNING;
          cur_d = k_q;
          sw_d = sw_q + 32'd1;
        end else begin
          k_d = k_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      rrts_pkg::S_FIND: begin
        if (status_q[k_q] != rrts_pkg::ST_FREE) begin
          if (k_q == LAST_IDX) begin
            code_d = rrts_pkg::RES_NO_SLOT;
          end else begin
            k_d = k_next;
          end
        end
      end
      rrts_pkg::S_MUL: prod_d = 32'(k_q) * 32'(stride_i);
      rrts_pkg::S_TOP: top_d = base_i + prod_q + 32'(stride_i) - rrts_pkg::FRAME_TOP_GAP;
      rrts_pkg::S_INIT: begin
        wr_en = 1'b1;
        wr_addr = k_q;
        wr_data = '0;
        wr_data.sp = top_q - rrts_pkg::FRAME_BYTES;
        tv_d[k_q] = 1'b1;
        st_we = 1'b1;
        st_idx = k_q;
        st_val = rrts_pkg::ST_READY;
        addr_d = top_q - 32'd4;
        j_d = '0;
      end
      rrts_pkg::S_FRAME: begin
        res_o.slot = 3'(k_q);
        res_o.next_sp = top_q - rrts_pkg::FRAME_BYTES;
        res_o.mem_address = addr_q;
        res_o.mem_data = (j_q == 5'd0) ? rrts_pkg::FRAME_FLAGS
                       : (j_q == 5'd1) ? item_q.entry_address : 32'd0;
        res_o.last = (j_q == rrts_pkg::FRAME_LAST);
        if (out_free_i) begin
          res_load_o = 1'b1;
          addr_d = addr_q - 32'd4;
          j_d = j_q + 5'd1;
        end
      end
      rrts_pkg::S_EXIT: begin
        if (cur_q == '0) begin
          code_d = rrts_pkg::RES_EXIT_REFUSED;
        end else begin
          st_we = 1'b1;
          st_val = rrts_pkg::ST_FREE;
        end
      end
      rrts_pkg::S_EMIT: begin
        if (item_q.action == rrts_pkg::ACT_SCHEDULE) begin
          res_o.next_sp = row_q.sp;
          res_o.restore_dest = row_q.dest;
          res_o.restore_width = row_q.width;
          res_o.restore_height = row_q.height;
          res_o.restore_source = row_q.source;
        end
        res_load_o = out_free_i;
      end
      default: ;
    endcase
  end

  // live count tracks free <-> non-free transitions of the one status write
  assign st_old = status_q[st_idx];
  always_comb begin
    live_d = live_q;
    if (st_we) begin
      if (st_old == rrts_pkg::ST_FREE && st_val != rrts_pkg::ST_FREE) begin
        live_d = live_q + 1'b1;
      end else if (st_old != rrts_pkg::ST_FREE && st_val == rrts_pkg::ST_FREE) begin
        live_d = live_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
      cur_q <= '0;
      sw_q <= '0;
      live_q <= CW'(1);
      tv_q <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        status_q[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
      end
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      sw_q <= sw_d;
      live_q <= live_d;
      tv_q <= tv_d;
      if (st_we) begin
        status_q[st_idx] <= st_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    row_q <= row_d;
    code_q <= code_d;
    k_q <= k_d;
    cnt_q <= cnt_d;
    top_q <= top_d;
    addr_q <= addr_d;
    prod_q <= prod_d;
    j_q <= j_d;
  end

  `RRTS_ASSERT(a_live_nonzero, clk_i, rst_ni, live_q != '0)
  `RRTS_ASSERT(a_slot0_never_free, clk_i, rst_ni, status_q[0] != rrts_pkg::ST_FREE)
  `RRTS_ASSERT(a_load_needs_room, clk_i, rst_ni, res_load_o |-> out_free_i)
  `RRTS_ASSERT(a_frame_bound, clk_i, rst_ni,
               (state_q == rrts_pkg::S_FRAME) |-> (j_q <= rrts_pkg::FRAME_LAST))
  `RRTS_ASSERT(a_no_mem_overlap, clk_i, rst_ni, !(rd_en && wr_en))

endmodule
`default_nettype wire

// File: rtl/core/round_robin_task_slot_scheduler_top.sv
// schedule: one probe of the context memory per slot visited
// start: scan of up to SLOT_COUNT-1 status entries, then S_MUL, S_TOP and S_INIT, then 17 frame items
// at one per cycle while the output register is free
// one item in work at a time; a waiting result holds only the final output register
// async active-low reset: slot 0 running, others free, tick counts and switch count zero, live count one
`default_nettype none
module round_robin_task_slot_scheduler_top #(
  parameter int unsigned SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] now_i,
  input  wire logic [31:0] saved_sp_i,
  input  wire logic [31:0] blit_dest_i,
  input  wire logic [31:0] blit_width_i,
  input  wire logic [31:0] blit_height_i,
  input  wire logic [31:0] blit_source_i,
  input  wire logic [31:0] entry_address_i,
  input  wire logic [31:0] sleep_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       slot_o,
  output logic [31:0]      next_sp_o,
  output logic [31:0]      restore_dest_o,
  output logic [31:0]      restore_width_o,
  output logic [31:0]      restore_height_o,
  output logic [31:0]      restore_source_o,
  output logic [3:0]       live_count_o,
  output logic [31:0]      switch_total_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      mem_data_o,
  output logic             last_o
);

  logic [31:0]                       base_q;
  logic [rrts_pkg::STRIDE_W-1:0]     stride_q;
  logic                              out_valid_q, out_free, res_load;
  rrts_pkg::result_t                 res, res_q;
  rrts_pkg::item_t                   item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rrts_pkg::DEF_BASE;
      stride_q <= rrts_pkg::DEF_STRIDE;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rrts_pkg::CFG_BASE) begin
        base_q <= cfg_wdata_i;
      end else begin
        stride_q <= cfg_wdata_i[rrts_pkg::STRIDE_W-1:0];
      end
    end
  end

  assign item.action = rrts_pkg::action_e'(action_i);
  assign item.now = now_i;
  assign item.saved_sp = saved_sp_i;
  assign item.blit_dest = blit_dest_i;
  assign item.blit_width = blit_width_i;
  assign item.blit_height = blit_height_i;
  assign item.blit_source = blit_source_i;
  assign item.entry_address = entry_address_i;
  assign item.sleep_ticks = sleep_ticks_i;

  assign out_free = !out_valid_q || out_ready_i;

  rrts_ctrl #(.SlotCount(SLOT_COUNT)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .base_i     (base_q),
    .stride_i   (stride_q),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = res_q.status;
  assign slot_o = res_q.slot;
  assign next_sp_o = res_q.next_sp;
  assign restore_dest_o = res_q.restore_dest;
  assign restore_width_o = res_q.restore_width;
  assign restore_height_o = res_q.restore_height;
  assign restore_source_o = res_q.restore_source;
  assign live_count_o = res_q.live_count;
  assign switch_total_o = res_q.switch_total;
  assign mem_address_o = res_q.mem_address;
  assign mem_data_o = res_q.mem_data;
  assign last_o = res_q.last;

endmodule
`default_nettype wire

// File: tb/sv/round_robin_task_slot_scheduler_top_test.sv
`default_nettype none
module round_robin_task_slot_scheduler_top_test;
  import rrts_pkg::*;

  localparam int unsigned NSLOT = SLOT_COUNT_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_BASE;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = ACT_SCHEDULE;
  logic [31:0] now_i = '0, saved_sp_i = '0, blit_dest_i = '0, blit_width_i = '0;
  logic [31:0] blit_height_i = '0, blit_source_i = '0, entry_address_i = '0;
  logic [31:0] sleep_ticks_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [2:0] slot_o;
  logic [31:0] next_sp_o, restore_dest_o, restore_width_o, restore_height_o;
  logic [31:0] restore_source_o, switch_total_o, mem_address_o, mem_data_o;
  logic [3:0] live_count_o;
  logic last_o;

  round_robin_task_slot_scheduler_top DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // scheduler image kept by the testbench
  slot_state_e sched_state[NSLOT];
  logic [31:0] sched_sp[NSLOT], sched_dest[NSLOT], sched_width[NSLOT];
  logic [31:0] sched_height[NSLOT], sched_source[NSLOT], sched_wake[NSLOT];
  logic [31:0] sched_ticks[NSLOT];
  logic [2:0] sched_cur;
  logic [31:0] sched_switches;
  logic [31:0] region_base;
  logic [20:0] region_stride;

  item_t pending_items[$];
  result_t expected_results[$];
  int mismatch_count = 0;
  int send_gap = 0, recv_gap = 0, recv_hold = 0;
  bit idling_on = 1'b1;
  int quiet_cycles = 0;

  function automatic logic [3:0] live_slots();
    logic [3:0] n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (sched_state[i] != ST_FREE) n++;
    return n;
  endfunction

  function automatic void push_result(res_code_e st, logic [2:0] sl, logic [31:0] sp,
                                      logic [31:0] d, logic [31:0] w, logic [31:0] h,
                                      logic [31:0] s, logic [31:0] addr,
                                      logic [31:0] data, logic lst);
    result_t r;
    r.status = st; r.slot = sl; r.next_sp = sp;
    r.restore_dest = d; r.restore_width = w; r.restore_height = h; r.restore_source = s;
    r.live_count = live_slots(); r.switch_total = sched_switches;
    r.mem_address = addr; r.mem_data = data; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_schedule_step(item_t it);
    int k, free_i;
    logic [2:0] pick;
    logic [31:0] top, fin;
    case (it.action)
      ACT_SCHEDULE: begin
        sched_sp[sched_cur] = it.saved_sp;
        sched_dest[sched_cur] = it.blit_dest;
        sched_width[sched_cur] = it.blit_width;
        sched_height[sched_cur] = it.blit_height;
        sched_source[sched_cur] = it.blit_source;
        sched_ticks[sched_cur] = sched_ticks[sched_cur] + 1;
        if (sched_state[sched_cur] == ST_RUNNING) sched_state[sched_cur] = ST_READY;
        pick = sched_cur;
        for (int i = 1; i <= NSLOT; i++) begin
          k = (sched_cur + i) % NSLOT;
          // due sleepers wake during the search
          if (sched_state[k] == ST_SLEEPING && $signed(it.now) >= $signed(sched_wake[k]))
            sched_state[k] = ST_READY;
          if (sched_state[k] == ST_READY || sched_state[k] == ST_RUNNING) begin
            pick = k[2:0];
            break;
          end
        end
        sched_cur = pick;
        sched_state[pick] = ST_RUNNING;
        sched_switches = sched_switches + 1;
        push_result(RES_OK, pick, sched_sp[pick], sched_dest[pick], sched_width[pick],
                    sched_height[pick], sched_source[pick], '0, '0, 1'b1);
      end
      ACT_START: begin
        free_i = 0;
        for (int i = 1; i < NSLOT; i++)
          if (sched_state[i] == ST_FREE) begin
            free_i = i;
            break;
          end
        if (free_i == 0) begin
          push_result(RES_NO_SLOT, sched_cur, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          top = region_base + 32'(free_i) * 32'(region_stride) + 32'(region_stride)
                - FRAME_TOP_GAP;
          fin = top - FRAME_BYTES;
          sched_sp[free_i] = fin; sched_wake[free_i] = '0; sched_ticks[free_i] = '0;
          sched_dest[free_i] = '0; sched_width[free_i] = '0;
          sched_height[free_i] = '0; sched_source[free_i] = '0;
          sched_state[free_i] = ST_READY;
          for (int j = 0; j < FRAME_WORDS; j++) begin
            top = top - 4;
            push_result(RES_OK, free_i[2:0], fin, '0, '0, '0, '0, top,
                        j == 0 ? FRAME_FLAGS : (j == 1 ? it.entry_address : '0),
                        j == FRAME_WORDS - 1);
          end
        end
      end
      ACT_SLEEP: begin
        sched_wake[sched_cur] = it.now + it.sleep_ticks;
        sched_state[sched_cur] = ST_SLEEPING;
        push_result(RES_OK, sched_cur, '0, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      default: begin
        if (sched_cur == 0) begin
          push_result(RES_EXIT_REFUSED, sched_cur, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          sched_state[sched_cur] = ST_FREE;
          push_result(RES_OK, sched_cur, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    item_t it;
    bit accepted;
    accepted = in_valid_i && in_ready_o;
    if (accepted) begin
      it.action = action_e'(action_i); it.now = now_i; it.saved_sp = saved_sp_i;
      it.blit_dest = blit_dest_i; it.blit_width = blit_width_i;
      it.blit_height = blit_height_i; it.blit_source = blit_source_i;
      it.entry_address = entry_address_i; it.sleep_ticks = sleep_ticks_i;
      predict_schedule_step(it);
    end
    if (rst_ni && (!in_valid_i || accepted)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        if (idling_on && $urandom_range(0, 6) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          in_valid_i <= 1'b0;
        end else begin
          it = pending_items.pop_front();
          action_i <= it.action; now_i <= it.now; saved_sp_i <= it.saved_sp;
          blit_dest_i <= it.blit_dest; blit_width_i <= it.blit_width;
          blit_height_i <= it.blit_height; blit_source_i <= it.blit_source;
          entry_address_i <= it.entry_address; sleep_ticks_i <= it.sleep_ticks;
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got.status = res_code_e'(status_o); got.slot = slot_o; got.next_sp = next_sp_o;
      got.restore_dest = restore_dest_o; got.restore_width = restore_width_o;
      got.restore_height = restore_height_o; got.restore_source = restore_source_o;
      got.live_count = live_count_o; got.switch_total = switch_total_o;
      got.mem_address = mem_address_o; got.mem_data = mem_data_o; got.last = last_o;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.slot != want.slot ||
            got.next_sp != want.next_sp || got.restore_dest != want.restore_dest ||
            got.restore_width != want.restore_width ||
            got.restore_height != want.restore_height ||
            got.restore_source != want.restore_source ||
            got.live_count != want.live_count || got.switch_total != want.switch_total ||
            got.mem_address != want.mem_address || got.mem_data != want.mem_data ||
            got.last != want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 6) == 0) begin
      recv_gap = $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t make_item(action_e act);
    item_t it;
    it.action = act; it.now = pick_word(); it.saved_sp = pick_word();
    it.blit_dest = pick_word(); it.blit_width = pick_word();
    it.blit_height = pick_word(); it.blit_source = pick_word();
    it.entry_address = pick_word();
    // mostly short sleeps so sleepers come due again
    it.sleep_ticks = $urandom_range(0, 3) == 0 ? pick_word() : 32'($urandom_range(0, 40));
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= data;
    if (idx == CFG_BASE) region_base = data; else region_stride = data[20:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (2 * NSLOT + 8) @(posedge clk_i);
  endtask

  task automatic random_items(int n);
    int r;
    action_e act;
    logic [31:0] clock_now;
    clock_now = $urandom;
    for (int i = 0; i < n; i++) begin
      item_t it;
      r = $urandom_range(0, 9);
      act = r < 4 ? ACT_SCHEDULE : (r < 6 ? ACT_START : (r < 8 ? ACT_SLEEP : ACT_EXIT));
      it = make_item(act);
      // a steadily advancing tick count, with an occasional jump anywhere
      clock_now = clock_now + $urandom_range(0, 12);
      if ($urandom_range(0, 7) != 0) it.now = clock_now;
      pending_items.push_back(it);
    end
  endtask

  initial begin
    item_t it;
    for (int i = 0; i < NSLOT; i++) begin
      sched_state[i] = i == 0 ? ST_RUNNING : ST_FREE;
      sched_ticks[i] = '0;
    end
    sched_cur = '0; sched_switches = '0;
    region_base = DEF_BASE; region_stride = DEF_STRIDE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: exit refused on slot 0, sleeping slot 0 kept on schedule, full table
    pending_items.push_back(make_item(ACT_EXIT));
    it = make_item(ACT_SLEEP); it.now = 32'h7FFF_FFFF; it.sleep_ticks = 32'h7FFF_FFFF;
    pending_items.push_back(it);
    it = make_item(ACT_SCHEDULE); it.now = 32'h8000_0000;
    pending_items.push_back(it);
    for (int i = 0; i < NSLOT; i++) begin
      it = make_item(ACT_START);
      it.entry_address = i[0] ? '1 : '0;
      pending_items.push_back(it);
    end
    it = make_item(ACT_SCHEDULE); it.saved_sp = '1; it.blit_dest = '1; it.blit_width = '1;
    it.blit_height = '1; it.blit_source = '1;
    pending_items.push_back(it);
    it = make_item(ACT_SLEEP); it.now = '0; it.sleep_ticks = 32'h8000_0000;
    pending_items.push_back(it);
    pending_items.push_back(make_item(ACT_SCHEDULE));
    pending_items.push_back(make_item(ACT_EXIT));
    pending_items.push_back(make_item(ACT_EXIT));
    pending_items.push_back(make_item(ACT_SCHEDULE));
    pending_items.push_back(make_item(ACT_START));
    drain();

    // stride of 2^20, base at the top so the frame address wraps
    write_reg(CFG_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_STRIDE, 32'h0010_0000);
    random_items(25);
    // receiver holds off while the sender keeps offering
    recv_hold = 300;
    drain();

    write_reg(CFG_BASE, 32'h0);
    write_reg(CFG_STRIDE, 32'd128);
    random_items(25);
    drain();

    write_reg(CFG_BASE, $urandom);
    write_reg(CFG_STRIDE, 32'($urandom_range(128, 1048576)));
    random_items(20);
    drain();

    idling_on = 1'b0;
    write_reg(CFG_BASE, DEF_BASE);
    write_reg(CFG_STRIDE, 32'(DEF_STRIDE));
    random_items(20);
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: round_robin_task_slot_scheduler_top.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_ctx_mem.sv
rtl/core/rrts_ctrl.sv
rtl/core/round_robin_task_slot_scheduler_top.sv
tb/sv/round_robin_task_slot_scheduler_top_test.sv
